/* src/tbsa_pkg.sv */
// Shared types, codes and helpers for the two-level bitmap slot allocator.
package tbsa_pkg;

  localparam int NUM_GROUPS_DEF      = 64;
  localparam int SLOTS_PER_GROUP_DEF = 64;
  localparam int IDX_W               = 6;
  localparam int ENC_W               = 64;

  // request kind
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // result status
  localparam logic [1:0] ST_ALLOC    = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RELEASED = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GRP,
    S_SLOT,
    S_RRD,
    S_RMW,
    S_FIN
  } state_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } enc_res_t;

  // lowest set bit: first nonzero byte, then first bit inside it
  function automatic enc_res_t lowest_set(input logic [ENC_W-1:0] v);
    enc_res_t r;
    logic [2:0] byte_i;
    logic [2:0] bit_i;
    logic [7:0] sel;
    r.found = |v;
    byte_i  = 3'd0;
    bit_i   = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (v[b*8 +: 8] != 8'd0) begin
        byte_i = 3'(b);
      end
    end
    sel = v[byte_i*8 +: 8];
    for (int i = 7; i >= 0; i--) begin
      if (sel[i]) begin
        bit_i = 3'(i);
      end
    end
    r.idx = {byte_i, bit_i};
    return r;
  endfunction

endpackage

/* src/tbsa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tbsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/two_level_bitmap_slot_allocator_core.sv */
// Two-level bitmap slot allocator: top full-map in flops, group bitmaps in RAM.
// Allocate: group search (S_GRP), then slot search (S_SLOT), repeated for each
//   group found exhausted on the way; pool full ends after the group search.
//   Release: read (S_RRD), then write back (S_RMW); out of range goes to S_FIN.
// One request in flight at a time (allocate or release), set by the shared
//   priority encoder and the read-then-write pass; result back-pressure stalls S_FIN.
// Reset: rst_n synchronous active low; clears the full map and the per-group
//   valid bits at once (an unwritten group reads as all free), so no clear pass.
module two_level_bitmap_slot_allocator_core #(
  parameter int NUM_GROUPS      = tbsa_pkg::NUM_GROUPS_DEF,
  parameter int SLOTS_PER_GROUP = tbsa_pkg::SLOTS_PER_GROUP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [5:0] rel_group, [11:6] rel_slot, [15:12] zero
  input  logic        in_tuser,   // [0] func
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [5:0] out_group, [11:6] out_slot, [15:12] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  import tbsa_pkg::*;

  localparam int GAW = $clog2(NUM_GROUPS);
  localparam int SAW = $clog2(SLOTS_PER_GROUP);

  // ---------------------------------------------------------------- registers
  state_t                     state_r, state_nxt;
  logic [NUM_GROUPS-1:0]      full_r, full_nxt;     // group is full
  logic [NUM_GROUPS-1:0]      vld_r, vld_nxt;       // group word written since reset
  logic [IDX_W-1:0]           req_group_r, req_group_nxt;
  logic [IDX_W-1:0]           req_slot_r, req_slot_nxt;
  logic [GAW-1:0]             cur_grp_r, cur_grp_nxt;
  logic [1:0]                 res_status_r, res_status_nxt;
  logic [IDX_W-1:0]           res_group_r, res_group_nxt;
  logic [IDX_W-1:0]           res_slot_r, res_slot_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [1:0]                 out_status_r, out_status_nxt;
  logic [IDX_W-1:0]           out_group_r, out_group_nxt;
  logic [IDX_W-1:0]           out_slot_r, out_slot_nxt;

  // ---------------------------------------------------------------- datapath
  logic                       in_acc;
  logic                       in_func;
  logic [IDX_W-1:0]           in_group;
  logic [IDX_W-1:0]           in_slot;
  logic                       rel_in_range;
  logic                       out_free;

  logic                       ram_we;
  logic [GAW-1:0]             ram_waddr;
  logic [SLOTS_PER_GROUP-1:0] ram_wdata;
  logic [GAW-1:0]             ram_raddr;
  logic [SLOTS_PER_GROUP-1:0] ram_rdata;

  logic [GAW-1:0]             word_grp;     // group whose word is on ram_rdata
  logic [SLOTS_PER_GROUP-1:0] word;         // ram data, zero if never written
  logic [SLOTS_PER_GROUP-1:0] word_set;
  logic [SLOTS_PER_GROUP-1:0] word_clr;
  logic [NUM_GROUPS-1:0]      open_grps;
  logic [ENC_W-1:0]           enc_in;       // shared encoder operand
  enc_res_t                   enc;

  assign in_func  = in_tuser;
  assign in_group = in_tdata[5:0];
  assign in_slot  = in_tdata[11:6];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign rel_in_range = (int'(in_group) < NUM_GROUPS) && (int'(in_slot) < SLOTS_PER_GROUP);

  assign open_grps = ~full_r;
  assign word_grp  = (state_r == S_RMW) ? req_group_r[GAW-1:0] : cur_grp_r;
  assign word      = vld_r[word_grp] ? ram_rdata : '0;

  // one priority encoder, shared by the group search and the slot search
  assign enc_in = (state_r == S_SLOT) ? ENC_W'(~word) : ENC_W'(open_grps);
  assign enc    = lowest_set(enc_in);

  assign word_set = word | (SLOTS_PER_GROUP'(1) << enc.idx[SAW-1:0]);
  assign word_clr = word & ~(SLOTS_PER_GROUP'(1) << req_slot_r[SAW-1:0]);

  tbsa_ram #(
    .WIDTH (SLOTS_PER_GROUP),
    .DEPTH (NUM_GROUPS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_func == FUNC_ALLOC) begin
            state_nxt = S_GRP;
          end else if (rel_in_range) begin
            state_nxt = S_RRD;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_GRP:  state_nxt = enc.found ? S_SLOT : S_FIN;
      S_SLOT: state_nxt = enc.found ? S_FIN : S_GRP;  // exhausted group: retry search
      S_RRD:  state_nxt = S_RMW;
      S_RMW:  state_nxt = S_FIN;
      S_FIN:  state_nxt = out_free ? S_IDLE : S_FIN;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs / datapath
  always_comb begin
    full_nxt       = full_r;
    vld_nxt        = vld_r;
    req_group_nxt  = req_group_r;
    req_slot_nxt   = req_slot_r;
    cur_grp_nxt    = cur_grp_r;
    res_status_nxt = res_status_r;
    res_group_nxt  = res_group_r;
    res_slot_nxt   = res_slot_r;
    ram_we         = 1'b0;
    ram_waddr      = cur_grp_r;
    ram_wdata      = word_set;
    ram_raddr      = cur_grp_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_group_nxt  = out_group_r;
    out_slot_nxt   = out_slot_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_group_nxt  = in_group;
          req_slot_nxt   = in_slot;
          res_status_nxt = ST_RELEASED;
          res_group_nxt  = '0;
          res_slot_nxt   = '0;
        end
      end
      S_GRP: begin
        if (enc.found) begin
          cur_grp_nxt = enc.idx[GAW-1:0];
          ram_raddr   = enc.idx[GAW-1:0];
        end else begin
          res_status_nxt = ST_FULL;
          res_group_nxt  = '0;
          res_slot_nxt   = '0;
        end
      end
      S_SLOT: begin
        if (enc.found) begin
          ram_we              = 1'b1;
          ram_waddr           = cur_grp_r;
          ram_wdata           = word_set;
          vld_nxt[cur_grp_r]  = 1'b1;
          full_nxt[cur_grp_r] = &word_set;
          res_status_nxt      = ST_ALLOC;
          res_group_nxt       = IDX_W'(cur_grp_r);
          res_slot_nxt        = enc.idx;
        end else begin
          full_nxt[cur_grp_r] = 1'b1;
        end
      end
      S_RRD: begin
        ram_raddr = req_group_r[GAW-1:0];
      end
      S_RMW: begin
        ram_we                         = 1'b1;
        ram_waddr                      = req_group_r[GAW-1:0];
        ram_wdata                      = word_clr;
        vld_nxt[req_group_r[GAW-1:0]]  = 1'b1;
        full_nxt[req_group_r[GAW-1:0]] = 1'b0;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_group_nxt  = res_group_r;
          out_slot_nxt   = res_slot_r;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      full_r      <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      full_r      <= full_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_group_r  <= req_group_nxt;
    req_slot_r   <= req_slot_nxt;
    cur_grp_r    <= cur_grp_nxt;
    res_status_r <= res_status_nxt;
    res_group_r  <= res_group_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_group_r  <= out_group_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'd0, out_slot_r, out_group_r};

  // ---------------------------------------------------------------- assertions
  // slot search only ever follows a group search (RAM read issued there)
  a_slot_after_grp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SLOT) |-> ($past(state_r) == S_GRP))
    else $error("slot search without preceding group search");

  // release write only follows its read cycle
  a_rmw_after_rrd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RMW) |-> ($past(state_r) == S_RRD))
    else $error("release write without preceding read");

  // only allocations carry indices
  a_zero_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_ALLOC)) |-> (out_tdata == 16'd0))
    else $error("non-allocate result with nonzero indices");

  // no new request is taken while a request is in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("ready while busy");

endmodule

/* dv/tb.sv */
// Testbench for the two-level bitmap slot allocator core: self-checking stream test.
`timescale 1ns / 1ps

module tb;
  import tbsa_pkg::*;

  localparam int NG          = NUM_GROUPS_DEF;
  localparam int NS          = SLOTS_PER_GROUP_DEF;
  localparam logic [63:0] GMASK = (NG >= 64) ? {64{1'b1}} : ((64'd1 << NG) - 64'd1);
  localparam logic [63:0] SMASK = (NS >= 64) ? {64{1'b1}} : ((64'd1 << NS) - 64'd1);
  localparam int IDLE_PCT    = 25;      // per-cycle idle chance on either side
  localparam int HOLD_CYCLES = 300;     // long receiver back-pressure stretch
  localparam int TAIL_CYCLES = 16;      // settle time after the last result
  localparam int CYCLE_LIMIT = 800000;  // run-away guard
  localparam int MIX_ITEMS   = 900;
  localparam int DIR_N       = 20;

  // one result beat: out_tuser and the packed out_tdata fields
  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] grp;
    logic [IDX_W-1:0] slot;
  } alloc_rsp_t;

  // directed row: request fields, then an optional literal expectation
  typedef struct packed {
    logic             f;
    logic [IDX_W-1:0] g;
    logic [IDX_W-1:0] s;
    logic             pinned;
    alloc_rsp_t       rsp;
  } dir_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        in_tuser   = FUNC_ALLOC;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;

  // shadow copy of the allocator state
  logic [63:0] full_map;
  logic [63:0] used_map [64];

  alloc_rsp_t  rsp_q [$];       // results still owed by the block, oldest first
  logic [11:0] held [$];        // {group, slot} handed out, used to aim releases
  int          mism_cnt  = 0;
  int          cycle_cnt = 0;
  int          hold_token = 0;  // bumped by the sender to request a long stall
  int          hold_seen  = 0;
  int          hold_left  = 0;
  logic        no_idle    = 1'b0;

  // Directed table. Pinned rows carry the literal answer; the rest go through
  // the shadow model. Covers alloc from empty, extreme release indices,
  // releasing a free slot, double release and ignored fields on allocate.
  dir_row_t dir_tab [DIR_N] = '{
    '{FUNC_ALLOC,   6'd0,  6'd0,  1'b1, '{ST_ALLOC,    6'd0, 6'd0}},
    '{FUNC_ALLOC,   6'd63, 6'd63, 1'b1, '{ST_ALLOC,    6'd0, 6'd1}},
    '{FUNC_RELEASE, 6'd0,  6'd0,  1'b1, '{ST_RELEASED, 6'd0, 6'd0}},
    '{FUNC_ALLOC,   6'd0,  6'd0,  1'b1, '{ST_ALLOC,    6'd0, 6'd0}},
    '{FUNC_RELEASE, 6'd63, 6'd63, 1'b1, '{ST_RELEASED, 6'd0, 6'd0}},
    '{FUNC_RELEASE, 6'd0,  6'd63, 1'b1, '{ST_RELEASED, 6'd0, 6'd0}},
    '{FUNC_RELEASE, 6'd63, 6'd0,  1'b1, '{ST_RELEASED, 6'd0, 6'd0}},
    '{FUNC_ALLOC,   6'd21, 6'd42, 1'b1, '{ST_ALLOC,    6'd0, 6'd2}},
    '{FUNC_RELEASE, 6'd0,  6'd1,  1'b1, '{ST_RELEASED, 6'd0, 6'd0}},
    '{FUNC_RELEASE, 6'd0,  6'd1,  1'b1, '{ST_RELEASED, 6'd0, 6'd0}},
    '{FUNC_ALLOC,   6'd42, 6'd21, 1'b1, '{ST_ALLOC,    6'd0, 6'd1}},
    '{FUNC_ALLOC,   6'd0,  6'd0,  1'b0, '0},
    '{FUNC_ALLOC,   6'd0,  6'd0,  1'b0, '0},
    '{FUNC_RELEASE, 6'd0,  6'd4,  1'b0, '0},
    '{FUNC_RELEASE, 6'd0,  6'd2,  1'b0, '0},
    '{FUNC_ALLOC,   6'd0,  6'd0,  1'b0, '0},
    '{FUNC_ALLOC,   6'd0,  6'd0,  1'b0, '0},
    '{FUNC_RELEASE, 6'd0,  6'd0,  1'b0, '0},
    '{FUNC_RELEASE, 6'd0,  6'd3,  1'b0, '0},
    '{FUNC_ALLOC,   6'd0,  6'd0,  1'b0, '0}
  };

  two_level_bitmap_slot_allocator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [5:0] rel_group, [11:6] rel_slot, [15:12] zero
    .in_tuser   (in_tuser),    // [0] func
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [5:0] out_group, [11:6] out_slot, [15:12] zero
    .out_tuser  (out_tuser)    // [1:0] status
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // index of the lowest set bit; caller guarantees v != 0
  function automatic int first_one(input logic [63:0] v);
    int idx;
    idx = 0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) idx = i;
    end
    return idx;
  endfunction

  // Shadow allocator: applies one request to the local maps and returns the
  // answer the block must give for it.
  function automatic alloc_rsp_t predict_rsp(input logic f, input logic [IDX_W-1:0] g,
                                             input logic [IDX_W-1:0] s);
    alloc_rsp_t  r;
    logic [63:0] open_m;
    logic [63:0] free_m;
    int          gi;
    int          si;
    bit          done;
    r    = '0;
    done = 1'b0;
    if (f == FUNC_RELEASE) begin
      if (int'(g) < NG && int'(s) < NS) begin
        used_map[g][s] = 1'b0;
        full_map[g]    = 1'b0;
      end
      r.status = ST_RELEASED;
      return r;
    end
    while (!done) begin
      open_m = ~full_map & GMASK;
      if (open_m == '0) begin
        // pool full: nothing changes
        r.status = ST_FULL;
        done     = 1'b1;
      end else begin
        gi     = first_one(open_m);
        free_m = ~used_map[gi] & SMASK;
        if (free_m == '0) begin
          // stale top bit: mark the group full and keep looking
          full_map[gi] = 1'b1;
        end else begin
          si = first_one(free_m);
          used_map[gi][si] = 1'b1;
          if ((used_map[gi] & SMASK) == SMASK) full_map[gi] = 1'b1;
          r.status = ST_ALLOC;
          r.grp    = IDX_W'(gi);
          r.slot   = IDX_W'(si);
          done     = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Offer one request beat, with random idle cycles ahead of it, and book the
  // expected answer once the beat is taken. Returns in the step of the
  // handshake with in_tvalid still high, so back-to-back beats stay gapless.
  task automatic send_req(input logic f, input logic [IDX_W-1:0] g,
                          input logic [IDX_W-1:0] s, input bit pinned,
                          input alloc_rsp_t pinned_rsp);
    alloc_rsp_t r;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {4'd0, s, g};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = predict_rsp(f, g, s);
    if (r.status == ST_ALLOC) held.push_back({r.grp, r.slot});
    rsp_q.push_back(pinned ? pinned_rsp : r);
  endtask

  // One random request: alloc_pct percent allocations (with junk in the
  // ignored fields), the rest releases, aimed at a held slot held_pct percent
  // of the time and otherwise at any index.
  task automatic send_mixed(input int alloc_pct, input int held_pct);
    int          k;
    logic [11:0] v;
    if ($urandom_range(99) < alloc_pct) begin
      send_req(FUNC_ALLOC, IDX_W'($urandom), IDX_W'($urandom), 1'b0, '0);
    end else if (held.size() > 0 && $urandom_range(99) < held_pct) begin
      k = $urandom_range(held.size() - 1);
      v = held[k];
      held.delete(k);
      send_req(FUNC_RELEASE, v[11:6], v[5:0], 1'b0, '0);
    end else begin
      send_req(FUNC_RELEASE, IDX_W'($urandom), IDX_W'($urandom), 1'b0, '0);
    end
  endtask

  // Result side: check each accepted beat against the oldest booked answer,
  // then pick out_tready for the next cycle. Signals are read right after the
  // edge, before any nonblocking update, so they hold their pre-edge values.
  always @(posedge clk) begin
    alloc_rsp_t got;
    alloc_rsp_t want;
    got = '{out_tuser, out_tdata[5:0], out_tdata[11:6]};
    if (rst_n && out_tvalid && out_tready) begin
      if (rsp_q.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= 10)
          $display("unexpected result beat: status=%0d grp=%0d slot=%0d",
                   got.status, got.grp, got.slot);
      end else begin
        want = rsp_q.pop_front();
        if (got.status != want.status || got.grp != want.grp || got.slot != want.slot ||
            out_tdata[15:12] != 4'd0) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display({"result mismatch: exp status=%0d grp=%0d slot=%0d, ",
                      "got status=%0d grp=%0d slot=%0d pad=%0h"},
                     want.status, want.grp, want.slot, got.status, got.grp, got.slot,
                     out_tdata[15:12]);
        end
      end
    end
    // ready pattern: long hold on request, none during the gapless window,
    // otherwise random stalls
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen  = hold_token;
      hold_left  = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (no_idle) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    full_map = '0;
    for (int g = 0; g < 64; g++) used_map[g] = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    for (int i = 0; i < DIR_N; i++) begin
      send_req(dir_tab[i].f, dir_tab[i].g, dir_tab[i].s, dir_tab[i].pinned,
               dir_tab[i].rsp);
    end

    // mixed traffic, allocation-heavy, with the pressure events folded in
    for (int i = 0; i < MIX_ITEMS; i++) begin
      if (i == 200) no_idle <= 1'b1;
      if (i == 450) no_idle <= 1'b0;
      // long receiver stall while beats keep coming: block backs up
      if (i == 600) hold_token <= hold_token + 1;
      if (i == 800) begin
        // sender pause: let every owed result come back first
        in_tvalid <= 1'b0;
        while (rsp_q.size() != 0) @(posedge clk);
      end
      send_mixed(70, 75);
    end

    // balanced churn: holes reopen slots, refills take them again
    for (int i = 0; i < 200; i++) send_mixed(50, 90);

    // release-heavy tail
    for (int i = 0; i < 180; i++) send_mixed(30, 80);

    in_tvalid <= 1'b0;
    while (rsp_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mism_cnt == 0 && rsp_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
